### sv/pswg_pkg.sv
package pswg_pkg;

   // Datapath widths
   localparam int SUM_W  = 58;   // accumulator of the shared add/sub unit
   localparam int ERR_W  = 17;   // target - sample, sample difference
   localparam int INT_W  = 41;   // stored integral, within +/- (2^40 - 1)
   localparam int PRE_W  = 42;   // integral plus error * ticks before the guard
   localparam int DRV_W  = 50;   // sum after the Q8.8 shift
   localparam int CNT_W  = 4;    // 16 steps per multiply or divide

   // Configuration register indexes (byte address = 8 * index)
   localparam logic [2:0] REG_TARGET         = 3'd0;
   localparam logic [2:0] REG_GAIN_P         = 3'd1;
   localparam logic [2:0] REG_GAIN_I         = 3'd2;
   localparam logic [2:0] REG_GAIN_D         = 3'd3;
   localparam logic [2:0] REG_INTEGRAL_BAND  = 3'd4;
   localparam logic [2:0] REG_INTEGRAL_LIMIT = 3'd5;
   localparam logic [2:0] REG_DRIVE_LIMIT    = 3'd6;

   localparam logic [14:0] DRIVE_LIMIT_RESET = 15'h7fff;

   // Sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ACC_MUL,    // integral += error * ticks, shift-add
      ST_INT_UPD,    // band / sign / limit guard on the integral
      ST_DIV,        // |sample difference| / ticks, restoring
      ST_DERIV,      // apply sign to the quotient
      ST_GAIN_P,     // sum += gain_p * error
      ST_GAIN_I,     // sum += gain_i * integral
      ST_GAIN_D,     // sum -= gain_d * derivative
      ST_ROUND,      // bias negative sums so the shift truncates toward zero
      ST_SAT         // shift, saturate, load the output register
   } state_type;

endpackage

### sv/pid_step_windup_guard_core.sv
// Channel   Dir  Handshake             Payload
// req_      in   tvalid/tready         tdata[15:0] sample, tdata[31:16] elapsed_ticks
// rsp_      out  tvalid/tready         tdata[15:0] drive, tuser saturated
// csr_      in   APB psel/penable      64-bit registers at byte address 8 * index
//
// A transaction is taken while the sequencer is idle, then one
// shared 58-bit add/sub unit runs four 16-step shift-add multiplies and one
// 16-step restoring divide, plus four more steps for the guard, sign,
// rounding and saturation.
// req_tready is high only while the sequencer is idle; a finished result sits
// in the output register, so the next transaction is taken while it waits.
// Synchronous active-high reset clears control state, config and state; the drive limit resets to 7fff.
module pid_step_windup_guard_core (
   input  logic        clock,
   input  logic        reset,
   // input stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,    // [15:0] sample, [31:16] elapsed_ticks
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,    // [15:0] drive
   output logic        rsp_tuser,    // [0] saturated
   // register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [5:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready
);
   import pswg_pkg::*;

   // Configuration registers
   logic [15:0] target_ff;
   logic [15:0] gain_p_ff;
   logic [15:0] gain_i_ff;
   logic [15:0] gain_d_ff;
   logic [15:0] band_ff;
   logic [39:0] ilimit_ff;
   logic [14:0] dlimit_ff;

   // State and datapath registers
   state_type        state_ff, state_in;
   logic [INT_W-1:0] integral_ff, integral_in;
   logic [15:0]      prev_ff, prev_in;
   logic [ERR_W-1:0] error_ff, error_in;
   logic [ERR_W-1:0] diff_ff, diff_in;
   logic [ERR_W-1:0] deriv_ff, deriv_in;
   logic [15:0]      ticks_ff, ticks_in;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [SUM_W-1:0] mcand_ff, mcand_in;
   logic [15:0]      mplier_ff, mplier_in;
   logic [15:0]      rem_ff, rem_in;
   logic [15:0]      num_ff, num_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [15:0]      rsp_drive_ff, rsp_drive_in;
   logic             rsp_sat_ff, rsp_sat_in;

   // Shared add/sub unit
   logic [SUM_W-1:0] add_a, add_b, add_res;
   logic             add_sub;

   logic req_fire, csr_wr, step_last, out_free;
   logic [15:0] in_sample, in_ticks;

   assign in_sample  = req_tdata[15:0];
   assign in_ticks   = req_tdata[31:16];
   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign step_last  = &cnt_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign add_res = add_a + (add_sub ? ~add_b : add_b) + {{(SUM_W-1){1'b0}}, add_sub};

   // Register port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      unique case (csr_paddr[5:3])
         REG_TARGET:         csr_prdata = {48'd0, target_ff};
         REG_GAIN_P:         csr_prdata = {48'd0, gain_p_ff};
         REG_GAIN_I:         csr_prdata = {48'd0, gain_i_ff};
         REG_GAIN_D:         csr_prdata = {48'd0, gain_d_ff};
         REG_INTEGRAL_BAND:  csr_prdata = {48'd0, band_ff};
         REG_INTEGRAL_LIMIT: csr_prdata = {24'd0, ilimit_ff};
         REG_DRIVE_LIMIT:    csr_prdata = {49'd0, dlimit_ff};
         default:            csr_prdata = 64'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= '0;
         gain_p_ff <= '0;
         gain_i_ff <= '0;
         gain_d_ff <= '0;
         band_ff   <= '0;
         ilimit_ff <= '0;
         dlimit_ff <= DRIVE_LIMIT_RESET;
      end else if (csr_wr) begin
         unique case (csr_paddr[5:3])
            REG_TARGET:         target_ff <= csr_pwdata[15:0];
            REG_GAIN_P:         gain_p_ff <= csr_pwdata[15:0];
            REG_GAIN_I:         gain_i_ff <= csr_pwdata[15:0];
            REG_GAIN_D:         gain_d_ff <= csr_pwdata[15:0];
            REG_INTEGRAL_BAND:  band_ff   <= csr_pwdata[15:0];
            REG_INTEGRAL_LIMIT: ilimit_ff <= csr_pwdata[39:0];
            REG_DRIVE_LIMIT:    dlimit_ff <= csr_pwdata[14:0];
            default: ;
         endcase
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:    if (req_fire) state_in = ST_ACC_MUL;
         ST_ACC_MUL: if (step_last) state_in = ST_INT_UPD;
         ST_INT_UPD: state_in = ST_DIV;
         ST_DIV:     if (step_last) state_in = ST_DERIV;
         ST_DERIV:   state_in = ST_GAIN_P;
         ST_GAIN_P:  if (step_last) state_in = ST_GAIN_I;
         ST_GAIN_I:  if (step_last) state_in = ST_GAIN_D;
         ST_GAIN_D:  if (step_last) state_in = ST_ROUND;
         ST_ROUND:   state_in = ST_SAT;
         ST_SAT:     if (out_free) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // Datapath control and next values
   logic [SUM_W-1:0] err_ext, int_ext, der_ext;
   logic [ERR_W-1:0] err_mag, quo_neg;
   logic [PRE_W-1:0] pre, lim_pos, lim_neg;
   logic             int_clear, int_hi, int_lo;
   logic [16:0]      div_shift;
   logic             div_ok;
   logic [DRV_W-1:0] drv, dlim_pos, dlim_neg;
   logic             drv_hi, drv_lo;

   assign err_ext  = {{(SUM_W-ERR_W){error_ff[ERR_W-1]}}, error_ff};
   assign int_ext  = {{(SUM_W-INT_W){integral_ff[INT_W-1]}}, integral_ff};
   assign der_ext  = {{(SUM_W-ERR_W){deriv_ff[ERR_W-1]}}, deriv_ff};
   assign err_mag  = error_ff[ERR_W-1] ? (~error_ff + 1'b1) : error_ff;
   assign quo_neg  = ~{1'b0, num_ff} + 1'b1;

   assign pre      = sum_ff[PRE_W-1:0];
   assign lim_pos  = {2'b00, ilimit_ff};
   assign lim_neg  = ~lim_pos + 1'b1;
   assign int_clear = (err_mag > {1'b0, band_ff}) || (error_ff == '0) ||
                      (pre == '0) || (pre[PRE_W-1] != error_ff[ERR_W-1]);
   assign int_hi   = $signed(pre) > $signed(lim_pos);
   assign int_lo   = $signed(pre) < $signed(lim_neg);

   assign div_shift = {rem_ff, num_ff[15]};
   assign div_ok    = !add_res[SUM_W-1];

   assign drv      = sum_ff[SUM_W-1:8];
   assign dlim_pos = {{(DRV_W-15){1'b0}}, dlimit_ff};
   assign dlim_neg = ~dlim_pos + 1'b1;
   assign drv_hi   = $signed(drv) > $signed(dlim_pos);
   assign drv_lo   = $signed(drv) < $signed(dlim_neg);

   // Shared unit operand select
   always_comb begin
      add_a   = sum_ff;
      add_b   = mcand_ff;
      add_sub = 1'b0;
      unique case (state_ff)
         ST_ACC_MUL, ST_GAIN_P, ST_GAIN_I, ST_GAIN_D: begin
            // gain bit 15 has negative weight
            add_sub = ((state_ff != ST_ACC_MUL) && step_last) ^
                      (state_ff == ST_GAIN_D);
         end
         ST_DIV: begin
            // trial subtract of the divisor
            add_a   = {{(SUM_W-17){1'b0}}, div_shift};
            add_b   = {{(SUM_W-16){1'b0}}, ticks_ff};
            add_sub = 1'b1;
         end
         ST_ROUND: begin
            add_b = sum_ff[SUM_W-1] ? SUM_W'(255) : '0;
         end
         default: ;
      endcase
   end

   always_comb begin
      integral_in  = integral_ff;
      prev_in      = prev_ff;
      error_in     = error_ff;
      diff_in      = diff_ff;
      deriv_in     = deriv_ff;
      ticks_in     = ticks_ff;
      sum_in       = sum_ff;
      mcand_in     = mcand_ff;
      mplier_in    = mplier_ff;
      rem_in       = rem_ff;
      num_in       = num_ff;
      cnt_in       = cnt_ff + 1'b1;
      rsp_drive_in = rsp_drive_ff;
      rsp_sat_in   = rsp_sat_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      unique case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            // take the transaction, start integral += error * ticks
            if (req_fire) begin
               error_in  = {target_ff[15], target_ff} - {in_sample[15], in_sample};
               diff_in   = {in_sample[15], in_sample} - {prev_ff[15], prev_ff};
               prev_in   = in_sample;
               ticks_in  = in_ticks;
               sum_in    = int_ext;
               mcand_in  = {{(SUM_W-ERR_W){error_in[ERR_W-1]}}, error_in};
               mplier_in = in_ticks;
            end
         end
         ST_ACC_MUL, ST_GAIN_P, ST_GAIN_I, ST_GAIN_D: begin
            // one shift-add step
            if (mplier_ff[0]) sum_in = add_res;
            mcand_in  = mcand_ff << 1;
            mplier_in = mplier_ff >> 1;
            if (step_last) begin
               unique case (state_ff)
                  ST_GAIN_P: begin
                     mcand_in  = int_ext;
                     mplier_in = gain_i_ff;
                  end
                  ST_GAIN_I: begin
                     mcand_in  = der_ext;
                     mplier_in = gain_d_ff;
                  end
                  default: ;
               endcase
            end
         end
         ST_INT_UPD: begin
            // windup guard, then set up the divider
            priority if (int_clear) integral_in = '0;
            else if (int_hi)        integral_in = lim_pos[INT_W-1:0];
            else if (int_lo)        integral_in = lim_neg[INT_W-1:0];
            else                    integral_in = pre[INT_W-1:0];
            num_in = diff_ff[ERR_W-1] ? 16'(~diff_ff + 1'b1) : diff_ff[15:0];
            rem_in = '0;
            cnt_in = '0;
         end
         ST_DIV: begin
            // restoring step
            rem_in  = div_ok ? add_res[15:0] : div_shift[15:0];
            num_in  = {num_ff[14:0], div_ok};
         end
         ST_DERIV: begin
            // signed quotient, zero when ticks are zero; set up gain_p * error
            if (ticks_ff == '0)           deriv_in = '0;
            else if (diff_ff[ERR_W-1])    deriv_in = quo_neg;
            else                          deriv_in = {1'b0, num_ff};
            sum_in    = '0;
            mcand_in  = err_ext;
            mplier_in = gain_p_ff;
            cnt_in    = '0;
         end
         ST_ROUND: begin
            sum_in = add_res;
         end
         ST_SAT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_sat_in   = drv_hi || drv_lo;
               priority if (drv_hi) rsp_drive_in = dlim_pos[15:0];
               else if (drv_lo)     rsp_drive_in = dlim_neg[15:0];
               else                 rsp_drive_in = drv[15:0];
            end
         end
         default: ;
      endcase
   end

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         integral_ff  <= '0;
         prev_ff      <= '0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         integral_ff  <= integral_in;
         prev_ff      <= prev_in;
         cnt_ff       <= cnt_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      error_ff     <= error_in;
      diff_ff      <= diff_in;
      deriv_ff     <= deriv_in;
      ticks_ff     <= ticks_in;
      sum_ff       <= sum_in;
      mcand_ff     <= mcand_in;
      mplier_ff    <= mplier_in;
      rem_ff       <= rem_in;
      num_ff       <= num_in;
      rsp_drive_ff <= rsp_drive_in;
      rsp_sat_ff   <= rsp_sat_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_drive_ff;
   assign rsp_tuser  = rsp_sat_ff;

   // Checks
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == ST_ACC_MUL))
      else $error("accepted transaction did not start the multiply");

   a_zero_error_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_INT_UPD && error_ff == '0) |=> (integral_ff == '0))
      else $error("integral not cleared on zero error");

   a_zero_ticks_deriv: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DERIV && ticks_ff == '0) |=> (deriv_ff == '0))
      else $error("derivative not zero for zero ticks");

   a_sat_at_limit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_sat_ff) |->
         (rsp_drive_ff == {1'b0, dlimit_ff} ||
          rsp_drive_ff == (16'd0 - {1'b0, dlimit_ff})))
      else $error("saturated drive not at the limit");

   a_sat_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SAT && rsp_valid_ff && !rsp_tready) |=> (state_ff == ST_SAT))
      else $error("result overwritten while the output register was full");

endmodule

### bench/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import pswg_pkg::*;

   // index past the last register, writes must be dropped
   localparam logic [2:0] REG_SPARE = 3'd7;
   localparam int QUIET_LIMIT  = 5000;
   localparam int DRAIN_CYCLES = 200;
   localparam int SEGMENTS     = 6;
   localparam int SEG_ITEMS    = 240;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;    // [15:0] sample, [31:16] elapsed_ticks
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;    // [15:0] drive
   logic        rsp_tuser;    // [0] saturated
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [5:0]  csr_paddr;
   logic [63:0] csr_pwdata;
   logic [63:0] csr_prdata;
   logic        csr_pready;

   int send_idle_pct;
   int recv_idle_pct;
   int run_sign;
   int run_left;

   typedef struct packed {
      logic signed [15:0] drive;
      logic               saturated;
   } drive_word_type;

   // Mirror of the controller: config, integral, last sample, pending drives
   class drive_predictor_type;
      longint target, gain_p, gain_i, gain_d;
      longint band, int_limit, drv_limit;
      longint integral, last_sample;
      drive_word_type drive_due[$];
      int errors;
      int checked;

      function new();
         target      = 0;
         gain_p      = 0;
         gain_i      = 0;
         gain_d      = 0;
         band        = 0;
         int_limit   = 0;
         drv_limit   = DRIVE_LIMIT_RESET;
         integral    = 0;
         last_sample = 0;
         errors      = 0;
         checked     = 0;
      endfunction

      function void set_reg(logic [2:0] idx, logic [63:0] v);
         case (idx)
            REG_TARGET:         target    = $signed(v[15:0]);
            REG_GAIN_P:         gain_p    = $signed(v[15:0]);
            REG_GAIN_I:         gain_i    = $signed(v[15:0]);
            REG_GAIN_D:         gain_d    = $signed(v[15:0]);
            REG_INTEGRAL_BAND:  band      = v[15:0];
            REG_INTEGRAL_LIMIT: int_limit = v[39:0];
            REG_DRIVE_LIMIT:    drv_limit = v[14:0];
            default: ;
         endcase
      endfunction

      function longint sgn(longint v);
         if (v > 0) return 1;
         if (v < 0) return -1;
         return 0;
      endfunction

      function longint mag(longint v);
         return (v < 0) ? -v : v;
      endfunction

      // One control step: windup-guarded integral, derivative on measurement
      function void take_sample(logic [15:0] smp_bits, logic [15:0] tick_bits);
         logic signed [15:0] smp_s;
         longint smp, ticks, err, deriv, sum, drv;
         logic sat;
         smp_s = smp_bits;
         smp   = smp_s;
         ticks = tick_bits;
         err   = target - smp;
         deriv = 0;
         sat   = 1'b0;

         integral += err * ticks;
         if (mag(err) > band || err == 0 || sgn(integral) != sgn(err))
            integral = 0;
         else if (mag(integral) > int_limit)
            integral = int_limit * sgn(integral);

         if (ticks != 0)
            deriv = (smp - last_sample) / ticks;

         // Q8.8 gains, truncated toward zero
         sum = gain_p * err + gain_i * integral - gain_d * deriv;
         drv = sum / 256;
         if (mag(drv) > drv_limit) begin
            drv = drv_limit * sgn(drv);
            sat = 1'b1;
         end
         last_sample = smp;
         drive_due.push_back('{drive: drv[15:0], saturated: sat});
      endfunction

      task report_mismatch(string msg);
         $display("mismatch at %0t: %s", $time, msg);
         errors++;
      endtask

      task check_drive(logic [15:0] drive, logic sat);
         drive_word_type due;
         if (drive_due.size() == 0) begin
            report_mismatch($sformatf("drive %0d arrived with nothing pending",
                                      $signed(drive)));
            return;
         end
         due = drive_due.pop_front();
         if (drive !== due.drive)
            report_mismatch($sformatf("result %0d drive got %0d want %0d",
                                      checked, $signed(drive), due.drive));
         if (sat !== due.saturated)
            report_mismatch($sformatf("result %0d saturated got %0b want %0b",
                                      checked, sat, due.saturated));
         checked++;
      endtask
   endclass

   drive_predictor_type sb = new();

   pid_step_windup_guard_core uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Result side: random back-pressure, capture and check transactions
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      if (!reset) begin
         if (req_tvalid && req_tready)
            sb.take_sample(req_tdata[15:0], req_tdata[31:16]);
         if (rsp_tvalid && rsp_tready)
            sb.check_drive(rsp_tdata, rsp_tuser);
      end
   end

   // Watchdog: too long without any transaction ends the run
   wire traffic = (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
                  (csr_psel && csr_penable);

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (traffic)
            quiet = 0;
         else
            quiet++;
      end
      $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
      $display("RESULT: ERROR");
      $finish;
   end

   // APB write, setup then access, then the bus goes idle
   task csr_write(logic [2:0] idx, logic [63:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 3'b000};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      sb.set_reg(idx, value);
      @(posedge clock);
   endtask

   // valid stays high into the next item unless an idle gap is drawn
   task send_item(logic [15:0] smp, logic [15:0] ticks);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {ticks, smp};
      do @(posedge clock); while (!req_tready);
   endtask

   // drop valid, then wait for every pending drive to come back
   task wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.drive_due.size() != 0)
         @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   function logic [63:0] pick_setting(logic [63:0] lo, logic [63:0] hi,
                                      logic [63:0] rnd);
      case ($urandom_range(0, 4))
         0:       return lo;
         1:       return hi;
         default: return rnd;
      endcase
   endfunction

   // either a full-range gain or a modest one around zero
   function logic [63:0] gain_draw();
      longint g;
      g = $urandom_range(0, 1200);
      g -= 600;
      return $urandom_range(0, 1) ? 64'($urandom) : g;
   endfunction

   task load_random_setting();
      csr_write(REG_TARGET, pick_setting(64'h8000, 64'h7fff, {$urandom, $urandom}));
      csr_write(REG_GAIN_P, pick_setting(64'h8000, 64'h7fff, gain_draw()));
      csr_write(REG_GAIN_I, pick_setting(64'h8000, 64'h7fff, gain_draw()));
      csr_write(REG_GAIN_D, pick_setting(64'h8000, 64'h7fff, gain_draw()));
      csr_write(REG_INTEGRAL_BAND, pick_setting(64'h0, 64'hffff,
         $urandom_range(0, 1) ? 64'($urandom_range(0, 65535))
                              : 64'($urandom_range(0, 400))));
      csr_write(REG_INTEGRAL_LIMIT, pick_setting(64'h0, 64'hff_ffff_ffff,
         $urandom_range(0, 1) ? 64'($urandom_range(1, 5000))
                              : {$urandom_range(0, 255), $urandom}));
      csr_write(REG_DRIVE_LIMIT, pick_setting(64'h0, 64'h7fff, 64'($urandom)));
      csr_write(REG_SPARE, {$urandom, $urandom});
   endtask

   // Mostly runs of same-sign errors inside the band so the integral winds up,
   // plus zero errors, band edges and raw noise
   task send_random();
      longint e, hi, s;
      logic signed [15:0] noise;
      logic [15:0] ticks;
      int pick;
      pick = $urandom_range(0, 99);
      if (run_left == 0) begin
         run_sign = $urandom_range(0, 1) ? 1 : -1;
         run_left = $urandom_range(3, 40);
      end
      run_left--;
      hi = (sb.band == 0) ? 1 : sb.band;
      if (pick < 60) begin
         if ($urandom_range(0, 1))
            e = $urandom_range(1, 32'((hi < 64) ? hi : 64));
         else
            e = $urandom_range(1, 32'(hi));
         s = sb.target - run_sign * e;
      end else if (pick < 70) begin
         s = sb.target;
      end else if (pick < 78) begin
         s = sb.target - run_sign * (sb.band + $urandom_range(0, 1));
      end else begin
         noise = 16'($urandom);
         s = noise;
      end
      if (s > 32767)  s = 32767;
      if (s < -32768) s = -32768;

      case ($urandom_range(0, 9))
         0:          ticks = 16'd0;
         1:          ticks = 16'hffff;
         2, 3, 4, 5: ticks = 16'($urandom_range(1, 16));
         6, 7, 8:    ticks = 16'($urandom_range(1, 2000));
         default:    ticks = 16'($urandom);
      endcase
      send_item(s[15:0], ticks);
   endtask

   initial begin
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      rsp_tready  <= 1'b0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      send_idle_pct = 28;
      recv_idle_pct = 78;
      run_sign = 1;
      run_left = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed: zero error, exact and clamped integral, exact and clamped drive
      csr_write(REG_TARGET, 64'd100);
      csr_write(REG_GAIN_P, 64'd256);
      csr_write(REG_GAIN_I, 64'd1);
      csr_write(REG_GAIN_D, 64'd128);
      csr_write(REG_INTEGRAL_BAND, 64'd1000);
      csr_write(REG_INTEGRAL_LIMIT, 64'd500);
      csr_write(REG_DRIVE_LIMIT, 64'd1000);
      send_item(16'sd100, 16'd10);
      send_item(16'sd90, 16'd50);
      send_item(16'sd90, 16'd60);
      send_item(16'sd100, 16'd0);
      send_item(-16'sd900, 16'd0);
      send_item(-16'sd901, 16'd0);
      send_item(16'sd1100, 16'd0);
      send_item(16'sd1101, 16'd0);
      // field extremes, zero ticks
      send_item(16'h8000, 16'd0);
      send_item(16'h7fff, 16'hffff);
      send_item(16'h8000, 16'hffff);
      send_item(16'h7fff, 16'd1);
      wait_idle();

      // zero drive limit; spare index must not disturb anything
      csr_write(REG_DRIVE_LIMIT, 64'd0);
      csr_write(REG_SPARE, 64'hffff_ffff_ffff_ffff);
      send_item(16'sd0, 16'd5);
      send_item(16'sd100, 16'd0);
      wait_idle();

      // register extremes
      csr_write(REG_TARGET, 64'h8000);
      csr_write(REG_GAIN_P, 64'h8000);
      csr_write(REG_GAIN_I, 64'h7fff);
      csr_write(REG_GAIN_D, 64'h8000);
      csr_write(REG_INTEGRAL_BAND, 64'hffff);
      csr_write(REG_INTEGRAL_LIMIT, 64'hff_ffff_ffff);
      csr_write(REG_DRIVE_LIMIT, 64'h7fff);
      send_item(16'h7fff, 16'hffff);
      send_item(16'h7fff, 16'hffff);
      send_item(16'h7fff, 16'hffff);
      send_item(16'h8000, 16'hffff);
      send_item(16'sd0, 16'd1);
      wait_idle();

      // Random segments, new setting each, three idling profiles
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         case (seg / 2)
            0: begin
               send_idle_pct = 28;
               recv_idle_pct = 78;
            end
            1: begin
               send_idle_pct = 78;
               recv_idle_pct = 28;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         load_random_setting();
         for (int n = 0; n < SEG_ITEMS; n++)
            send_random();
         wait_idle();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
